// ===== design/hgt_pkg.sv =====
// Shared types, field widths, operation codes and corner tables of the grid tetrahedralizer.
`default_nettype none

package hgt_pkg;

    localparam int OP_W    = 3;
    localparam int U_W     = 8;
    localparam int V_W     = 6;
    localparam int L_W     = 4;
    localparam int CU_W    = 9;
    localparam int CV_W    = 7;
    localparam int CL_W    = 5;
    localparam int PLANE_W = CU_W + CV_W;
    localparam int NODE_W  = 19;
    localparam int K_W     = 3;

    localparam int IN_FIELDS_W = OP_W + U_W + V_W + L_W;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 80;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = CU_W;

    localparam logic [OP_W-1:0] OP_TETRA  = 3'd0;
    localparam logic [OP_W-1:0] OP_TOP    = 3'd1;
    localparam logic [OP_W-1:0] OP_BOTTOM = 3'd2;
    localparam logic [OP_W-1:0] OP_INNER  = 3'd3;
    localparam logic [OP_W-1:0] OP_OUTER  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_U      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_V      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_LAYERS = 2'd2;

    localparam logic [K_W-1:0] TET_LAST = 3'd4;
    localparam logic [K_W-1:0] TRI_LAST = 3'd1;

    typedef logic [NODE_W-1:0] t_node;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            pat;
        logic            bad;
        t_node           base;
        t_node           row_u;
        t_node           row_n;
        logic [CV_W-1:0] v;
    } t_prod;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            pat;
        logic            bad;
        t_node [7:0]     corner;
    } t_item;

    // corner numbers 0..7: (u,v) (u+1,v) (u+1,v+1) (u,v+1), lower level then upper
    localparam logic [2:0] TET_TABLE [2][5][4] = '{
        '{ '{3'd0, 3'd1, 3'd3, 3'd4}, '{3'd2, 3'd3, 3'd1, 3'd6}, '{3'd5, 3'd4, 3'd6, 3'd1},
           '{3'd7, 3'd6, 3'd4, 3'd3}, '{3'd4, 3'd6, 3'd1, 3'd3} },
        '{ '{3'd1, 3'd2, 3'd0, 3'd5}, '{3'd3, 3'd0, 3'd2, 3'd7}, '{3'd4, 3'd7, 3'd5, 3'd0},
           '{3'd6, 3'd5, 3'd7, 3'd2}, '{3'd0, 3'd5, 3'd2, 3'd7} }
    };

    localparam logic [2:0] TRI_TABLE [4][2][2][3] = '{
        '{ '{ '{3'd3, 3'd1, 3'd0}, '{3'd1, 3'd3, 3'd2} },
           '{ '{3'd1, 3'd0, 3'd2}, '{3'd2, 3'd0, 3'd3} } },
        '{ '{ '{3'd4, 3'd5, 3'd6}, '{3'd6, 3'd7, 3'd4} },
           '{ '{3'd4, 3'd5, 3'd7}, '{3'd5, 3'd6, 3'd7} } },
        '{ '{ '{3'd0, 3'd1, 3'd4}, '{3'd5, 3'd4, 3'd1} },
           '{ '{3'd0, 3'd1, 3'd5}, '{3'd0, 3'd5, 3'd4} } },
        '{ '{ '{3'd2, 3'd3, 3'd6}, '{3'd7, 3'd6, 3'd3} },
           '{ '{3'd3, 3'd7, 3'd2}, '{3'd6, 3'd2, 3'd7} } }
    };

endpackage

`default_nettype wire

// ===== design/hgt_index.sv =====
// Input register, range check, forced coordinates and row/level products.
`default_nettype none

module hgt_index (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire [hgt_pkg::CU_W-1:0]           i_count_u,
    input  wire [hgt_pkg::CV_W-1:0]           i_count_v,
    input  wire [hgt_pkg::CL_W-1:0]           i_count_layers,
    input  wire [hgt_pkg::PLANE_W-1:0]        i_plane,
    input  wire                               i_cfg_ok,
    input  wire                               i_valid,
    output logic                              o_ready,
    input  wire [hgt_pkg::IN_FIELDS_W-1:0]    i_data,
    output logic                              o_valid,
    input  wire                               i_ready,
    output hgt_pkg::t_prod                    o_prod
);

    logic                              r_in_vld;
    logic [hgt_pkg::IN_FIELDS_W-1:0]   r_in;
    logic                              r_prod_vld;
    hgt_pkg::t_prod                    r_prod;
    hgt_pkg::t_prod                    n_prod;

    logic                              prod_rdy;
    logic [hgt_pkg::OP_W-1:0]          op;
    logic [hgt_pkg::U_W-1:0]           u;
    logic [hgt_pkg::V_W-1:0]           v;
    logic [hgt_pkg::L_W-1:0]           l;
    logic [hgt_pkg::CV_W-1:0]          v_eff;
    logic [hgt_pkg::CL_W-1:0]          l_eff;
    logic [hgt_pkg::CU_W-1:0]          u_inc;
    logic [hgt_pkg::CU_W-1:0]          un;

    assign prod_rdy = !r_prod_vld || i_ready;
    assign o_ready  = !r_in_vld || prod_rdy;

    assign op = r_in[hgt_pkg::OP_W-1:0];
    assign u  = r_in[hgt_pkg::OP_W +: hgt_pkg::U_W];
    assign v  = r_in[hgt_pkg::OP_W + hgt_pkg::U_W +: hgt_pkg::V_W];
    assign l  = r_in[hgt_pkg::OP_W + hgt_pkg::U_W + hgt_pkg::V_W +: hgt_pkg::L_W];

    always_comb begin
        // forced coordinate of a boundary face replaces the input one
        v_eff = {1'b0, v};
        l_eff = {1'b0, l};
        case (op)
            hgt_pkg::OP_TOP:    l_eff = '0;
            hgt_pkg::OP_BOTTOM: l_eff = i_count_layers - 5'd1;
            hgt_pkg::OP_INNER:  v_eff = '0;
            hgt_pkg::OP_OUTER:  v_eff = i_count_v - 7'd2;
            default:            ;
        endcase

        u_inc = {1'b0, u} + 9'd1;
        un    = (u_inc == i_count_u) ? '0 : u_inc;

        n_prod.op    = op;
        n_prod.pat   = u[0] ^ v_eff[0] ^ l_eff[0];
        n_prod.bad   = !i_cfg_ok || (op > hgt_pkg::OP_OUTER) || ({1'b0, u} >= i_count_u)
                       || (v_eff >= i_count_v - 7'd1) || (l_eff >= i_count_layers);
        n_prod.v     = v_eff;
        n_prod.base  = hgt_pkg::t_node'(l_eff) * hgt_pkg::t_node'(i_plane);
        n_prod.row_u = hgt_pkg::t_node'(u) * hgt_pkg::t_node'(i_count_v);
        n_prod.row_n = hgt_pkg::t_node'(un) * hgt_pkg::t_node'(i_count_v);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld   <= 1'b0;
            r_prod_vld <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_vld <= i_valid;
            end
            if (prod_rdy) begin
                r_prod_vld <= r_in_vld;
            end
        end
        if (o_ready && i_valid) begin
            r_in <= i_data;
        end
        if (prod_rdy && r_in_vld) begin
            r_prod <= n_prod;
        end
    end

    assign o_valid = r_prod_vld;
    assign o_prod  = r_prod;

endmodule

`default_nettype wire

// ===== design/hgt_corner.sv =====
// Eight corner node ids of the cell from the registered products.
`default_nettype none

module hgt_corner (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire [hgt_pkg::PLANE_W-1:0]   i_plane,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire hgt_pkg::t_prod          i_prod,
    output logic                         o_valid,
    input  wire                          i_ready,
    output hgt_pkg::t_item               o_item
);

    logic             r_vld;
    hgt_pkg::t_item   r_item;
    hgt_pkg::t_item   n_item;
    hgt_pkg::t_node   v_lo;
    hgt_pkg::t_node   v_hi;
    hgt_pkg::t_node   plane;

    assign o_ready = !r_vld || i_ready;

    always_comb begin
        v_lo  = hgt_pkg::t_node'(i_prod.v);
        v_hi  = v_lo + 19'd1;
        plane = hgt_pkg::t_node'(i_plane);

        n_item.op        = i_prod.op;
        n_item.pat       = i_prod.pat;
        n_item.bad       = i_prod.bad;
        n_item.corner[0] = i_prod.base + i_prod.row_u + v_lo;
        n_item.corner[1] = i_prod.base + i_prod.row_n + v_lo;
        n_item.corner[2] = i_prod.base + i_prod.row_n + v_hi;
        n_item.corner[3] = i_prod.base + i_prod.row_u + v_hi;
        n_item.corner[4] = i_prod.base + plane + i_prod.row_u + v_lo;
        n_item.corner[5] = i_prod.base + plane + i_prod.row_n + v_lo;
        n_item.corner[6] = i_prod.base + plane + i_prod.row_n + v_hi;
        n_item.corner[7] = i_prod.base + plane + i_prod.row_u + v_hi;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_vld;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// ===== design/hgt_emit.sv =====
// Element sequencer: one tetrahedron, triangle or error result per unstalled cycle to output reg.
`default_nettype none

module hgt_emit (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_valid,
    output logic                      o_ready,
    input  wire hgt_pkg::t_item       i_item,
    output logic                      o_valid,
    input  wire                       i_ready,
    output hgt_pkg::t_node [3:0]      o_nodes,
    output logic                      o_last,
    output logic                      o_bad
);

    logic [hgt_pkg::K_W-1:0]   r_k;
    logic                      r_ovld;
    hgt_pkg::t_node [3:0]      r_nodes;
    logic                      r_last;
    logic                      r_bad;

    logic                      load;
    logic                      last;
    logic [1:0]                face;
    hgt_pkg::t_node [3:0]      n_nodes;

    assign load = i_valid && (!r_ovld || i_ready);

    always_comb begin
        face    = 2'(i_item.op - hgt_pkg::OP_TOP);
        n_nodes = '0;
        if (i_item.bad) begin
            last = 1'b1;
        end else if (i_item.op == hgt_pkg::OP_TETRA) begin
            last = (r_k == hgt_pkg::TET_LAST);
            for (int j = 0; j < 4; j++) begin
                n_nodes[j] = i_item.corner[hgt_pkg::TET_TABLE[i_item.pat][r_k][j]];
            end
        end else begin
            last = (r_k == hgt_pkg::TRI_LAST);
            for (int j = 0; j < 3; j++) begin
                n_nodes[j] = i_item.corner[hgt_pkg::TRI_TABLE[face][i_item.pat][r_k[0]][j]];
            end
        end
    end

    // the item leaves the corner stage once its last element is loaded
    assign o_ready = load && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k    <= '0;
            r_ovld <= 1'b0;
        end else if (load) begin
            r_ovld <= 1'b1;
            r_k    <= last ? '0 : r_k + 3'd1;
        end else if (i_ready) begin
            r_ovld <= 1'b0;
        end
        if (load) begin
            r_nodes <= n_nodes;
            r_last  <= last;
            r_bad   <= i_item.bad;
        end
    end

    assign o_valid = r_ovld;
    assign o_nodes = r_nodes;
    assign o_last  = r_last;
    assign o_bad   = r_bad;

endmodule

`default_nettype wire

// ===== design/hex_grid_tetrahedralizer_top.sv =====
// A request passes from the input register through the product and corner stages to the
// output register. Results leave one per cycle from it while the output is not stalled:
// a cell request gives 5 results, a face 2 and an error 1, set by the element sequencer.
// Input, product and corner stages each hold one request, so requests overlap.
// Reset (synchronous, active low) empties the pipeline and sets the grid to 2 x 2 x 1.
`default_nettype none

module hex_grid_tetrahedralizer_top #(
    parameter int MAX_U      = 256,
    parameter int MAX_V      = 64,
    parameter int MAX_LAYERS = 16
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_wr_en,
    input  wire [hgt_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire [hgt_pkg::CFG_DATA_W-1:0]        i_cfg_wdata,
    input  wire                                  i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // op[2:0], u[10:3], v[16:11], layer[20:17], zero fill
    input  wire [hgt_pkg::IN_TDATA_W-1:0]        i_s_axis_tdata,
    output logic                                 o_m_axis_tvalid,
    input  wire                                  i_m_axis_tready,
    // node_first[18:0], node_second[37:19], node_third[56:38], node_fourth[75:57], zero fill
    output logic [hgt_pkg::OUT_TDATA_W-1:0]      o_m_axis_tdata,
    output logic                                 o_m_axis_tlast,
    // bad_input[0]
    output logic                                 o_m_axis_tuser
);

    logic [hgt_pkg::CU_W-1:0]     r_count_u;
    logic [hgt_pkg::CV_W-1:0]     r_count_v;
    logic [hgt_pkg::CL_W-1:0]     r_count_layers;
    logic [hgt_pkg::PLANE_W-1:0]  r_plane;
    logic                         r_cfg_ok;

    logic                         w_prod_vld;
    logic                         w_prod_rdy;
    hgt_pkg::t_prod               w_prod;
    logic                         w_item_vld;
    logic                         w_item_rdy;
    hgt_pkg::t_item               w_item;
    hgt_pkg::t_node [3:0]         w_nodes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_u      <= 9'd2;
            r_count_v      <= 7'd2;
            r_count_layers <= 5'd1;
            r_plane        <= 16'd4;
            r_cfg_ok       <= 1'b1;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    hgt_pkg::CFG_COUNT_U:      r_count_u      <= i_cfg_wdata;
                    hgt_pkg::CFG_COUNT_V:      r_count_v      <= i_cfg_wdata[hgt_pkg::CV_W-1:0];
                    hgt_pkg::CFG_COUNT_LAYERS: r_count_layers <= i_cfg_wdata[hgt_pkg::CL_W-1:0];
                    default:                   ;
                endcase
            end
            r_plane  <= {7'd0, r_count_u} * {9'd0, r_count_v};
            r_cfg_ok <= (r_count_u >= 9'd2) && (32'(r_count_u) <= MAX_U) && !r_count_u[0]
                        && (r_count_v >= 7'd2) && (32'(r_count_v) <= MAX_V)
                        && (r_count_layers >= 5'd1) && (32'(r_count_layers) <= MAX_LAYERS);
        end
    end

    hgt_index u_index (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_count_u      (r_count_u),
        .i_count_v      (r_count_v),
        .i_count_layers (r_count_layers),
        .i_plane        (r_plane),
        .i_cfg_ok       (r_cfg_ok),
        .i_valid        (i_s_axis_tvalid),
        .o_ready        (o_s_axis_tready),
        .i_data         (i_s_axis_tdata[hgt_pkg::IN_FIELDS_W-1:0]),
        .o_valid        (w_prod_vld),
        .i_ready        (w_prod_rdy),
        .o_prod         (w_prod)
    );

    hgt_corner u_corner (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_plane (r_plane),
        .i_valid (w_prod_vld),
        .o_ready (w_prod_rdy),
        .i_prod  (w_prod),
        .o_valid (w_item_vld),
        .i_ready (w_item_rdy),
        .o_item  (w_item)
    );

    hgt_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_item_vld),
        .o_ready (w_item_rdy),
        .i_item  (w_item),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_nodes (w_nodes),
        .o_last  (o_m_axis_tlast),
        .o_bad   (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = {4'd0, w_nodes[3], w_nodes[2], w_nodes[1], w_nodes[0]};

    // an error result carries no nodes and closes its request
    a_bad_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tlast && (o_m_axis_tdata == '0))
        else $error("error result with node data or without tlast");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    // a request stays in the corner stage until the sequencer has loaded its last element
    a_item_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_item_vld && !w_item_rdy |=> w_item_vld && $stable(w_item))
        else $error("corner stage request dropped or changed before completion");

endmodule

`default_nettype wire
